[hdl/m52_pkg.sv]
package m52_pkg;

  localparam int unsigned NDIM    = 6;
  localparam int unsigned MANT_W  = 31;   // exp mantissa, Q1.30 in [1,2)
  localparam int unsigned SCALE_W = 43;   // length scale Q.24, below the distance cap
  localparam int unsigned FACT_W  = 31;   // per-dimension factor, Q.30, at most one
  localparam int unsigned IDX_W   = 3;

  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [63:0] LN2_Q30   = 64'd744261118;
  localparam logic [25:0] SQRT5_Q24 = 26'd37514995;
  // floor(x/3) = (x * DIV3_M) >> 37 for x below 2^37
  localparam logic [35:0] DIV3_M    = 36'd45812984491;
  localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
  localparam logic [24:0] ONE_Q24   = 25'h100_0000;

  localparam logic [IDX_W-1:0] REG_LOG_AMPLITUDE = 3'd0;
  localparam logic [IDX_W-1:0] REG_LOG_LENGTH_0  = 3'd1;
  localparam logic [IDX_W-1:0] REG_LOG_LENGTH_1  = 3'd2;
  localparam logic [IDX_W-1:0] REG_LOG_LENGTH_2  = 3'd3;
  localparam logic [IDX_W-1:0] REG_LOG_LENGTH_3  = 3'd4;
  localparam logic [IDX_W-1:0] REG_LOG_LENGTH_4  = 3'd5;
  localparam logic [IDX_W-1:0] REG_LOG_LENGTH_5  = 3'd6;

  typedef struct packed {
    logic [NDIM-1:0][SCALE_W-1:0] scale;
    logic [NDIM-1:0]              scale_big;
    logic [MANT_W-1:0]            amp_mant;
    logic signed [6:0]            amp_exp;
  } cfg_derived_t;

  function automatic logic [63:0] taylor_mul(logic [63:0] term, logic [63:0] y);
    logic [63:0] prod;
    prod = term * y;
    return prod >> 30;
  endfunction

  // 2^(idx/2^bits) in Q1.30, 24 truncated taylor terms of exp(idx*ln2/2^bits)
  function automatic logic [MANT_W-1:0] exp_rom_entry(int unsigned idx, int unsigned bits);
    logic [63:0] y;
    logic [63:0] term;
    logic [63:0] sum;
    y = (64'(idx) * LN2_Q30) >> bits;
    sum  = 64'h4000_0000;
    term = 64'h4000_0000;
    term = taylor_mul(term, y) / 64'd1;  sum = sum + term;
    term = taylor_mul(term, y) / 64'd2;  sum = sum + term;
    term = taylor_mul(term, y) / 64'd3;  sum = sum + term;
    term = taylor_mul(term, y) / 64'd4;  sum = sum + term;
    term = taylor_mul(term, y) / 64'd5;  sum = sum + term;
    term = taylor_mul(term, y) / 64'd6;  sum = sum + term;
    term = taylor_mul(term, y) / 64'd7;  sum = sum + term;
    term = taylor_mul(term, y) / 64'd8;  sum = sum + term;
    term = taylor_mul(term, y) / 64'd9;  sum = sum + term;
    term = taylor_mul(term, y) / 64'd10; sum = sum + term;
    term = taylor_mul(term, y) / 64'd11; sum = sum + term;
    term = taylor_mul(term, y) / 64'd12; sum = sum + term;
    term = taylor_mul(term, y) / 64'd13; sum = sum + term;
    term = taylor_mul(term, y) / 64'd14; sum = sum + term;
    term = taylor_mul(term, y) / 64'd15; sum = sum + term;
    term = taylor_mul(term, y) / 64'd16; sum = sum + term;
    term = taylor_mul(term, y) / 64'd17; sum = sum + term;
    term = taylor_mul(term, y) / 64'd18; sum = sum + term;
    term = taylor_mul(term, y) / 64'd19; sum = sum + term;
    term = taylor_mul(term, y) / 64'd20; sum = sum + term;
    term = taylor_mul(term, y) / 64'd21; sum = sum + term;
    term = taylor_mul(term, y) / 64'd22; sum = sum + term;
    term = taylor_mul(term, y) / 64'd23; sum = sum + term;
    term = taylor_mul(term, y) / 64'd24; sum = sum + term;
    return sum[MANT_W-1:0];
  endfunction

endpackage

[hdl/m52_exp_rom.sv]
module m52_exp_rom #(
  parameter int unsigned TBL_BITS = 8
) (
  input  logic [TBL_BITS-1:0]          idx,
  output logic [m52_pkg::MANT_W-1:0]   mant
);
  import m52_pkg::*;

  localparam int unsigned N = 1 << TBL_BITS;

  logic [MANT_W-1:0] entry [N];

  for (genvar g = 0; g < N; g++) begin : g_rom
    localparam logic [MANT_W-1:0] VAL = exp_rom_entry(g, TBL_BITS);
    assign entry[g] = VAL;
  end

  assign mant = entry[idx];

endmodule

[hdl/m52_cfg.sv]
module m52_cfg #(
  parameter int unsigned TBL_BITS = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [m52_pkg::IDX_W-1:0]    cfg_index,
  input  logic [15:0]                  cfg_data,
  output m52_pkg::cfg_derived_t        derived
);
  import m52_pkg::*;

  logic signed [15:0] log_amp;
  logic signed [15:0] log_len [NDIM];

  always_ff @(posedge clk) begin
    if (rst) begin
      log_amp <= '0;
      for (int i = 0; i < NDIM; i++) log_len[i] <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_LOG_AMPLITUDE: log_amp    <= cfg_data;
        REG_LOG_LENGTH_0:  log_len[0] <= cfg_data;
        REG_LOG_LENGTH_1:  log_len[1] <= cfg_data;
        REG_LOG_LENGTH_2:  log_len[2] <= cfg_data;
        REG_LOG_LENGTH_3:  log_len[3] <= cfg_data;
        REG_LOG_LENGTH_4:  log_len[4] <= cfg_data;
        REG_LOG_LENGTH_5:  log_len[5] <= cfg_data;
        default: ;
      endcase
    end
  end

  // first stage: exp argument times log2(e), Q.46
  logic signed [53:0] t_len [NDIM];
  logic signed [53:0] t_amp;
  logic signed [21:0] x16_len [NDIM];
  logic [60:0]        v_len [NDIM];

  for (genvar d = 0; d < NDIM; d++) begin : g_len
    logic signed [16:0] neg_l;
    logic [TBL_BITS-1:0] idx;
    logic [MANT_W-1:0]   m;
    logic [7:0]          shamt;

    assign neg_l      = -17'(log_len[d]);
    assign x16_len[d] = {neg_l, 5'b0};

    assign idx   = t_len[d][45 -: TBL_BITS];
    // scale = m * 2^(k-6); shifted from a 30-bit headroom
    assign shamt    = 8'd36 - t_len[d][53:46];
    assign v_len[d] = {m, 30'b0} >> shamt[5:0];

    m52_exp_rom #(.TBL_BITS(TBL_BITS)) u_rom (.idx(idx), .mant(m));
  end

  logic signed [21:0]  amp_x16;
  logic [TBL_BITS-1:0] amp_idx;
  logic [MANT_W-1:0]   amp_m;

  assign amp_x16 = {log_amp, 6'b0};
  assign amp_idx = t_amp[45 -: TBL_BITS];

  m52_exp_rom #(.TBL_BITS(TBL_BITS)) u_amp_rom (.idx(amp_idx), .mant(amp_m));

  always_ff @(posedge clk) begin
    for (int i = 0; i < NDIM; i++) begin
      t_len[i]             <= x16_len[i] * $signed({1'b0, LOG2E_Q30});
      derived.scale[i]     <= v_len[i][SCALE_W-1:0];
      derived.scale_big[i] <= |v_len[i][60:SCALE_W];
    end
    t_amp            <= amp_x16 * $signed({1'b0, LOG2E_Q30});
    derived.amp_mant <= amp_m;
    derived.amp_exp  <= t_amp[52:46];
  end

endmodule

[hdl/m52_lane.sv]
module m52_lane #(
  parameter int unsigned TBL_BITS = 8
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [15:0]                   a,
  input  logic [15:0]                   b,
  input  logic [m52_pkg::SCALE_W-1:0]   scale,
  input  logic                          scale_big,
  output logic [m52_pkg::FACT_W-1:0]    factor
);
  import m52_pkg::*;

  logic [15:0]  a1, b1;
  logic [15:0]  diff2;
  logic [58:0]  p3;
  logic         big3;
  logic [37:0]  r32_4;
  logic         zero4;
  logic [35:0]  sq5;
  logic [29:0]  r24_5;
  logic [52:0]  tmag5;
  logic         zero5;
  logic [53:0]  pp_hi6, pp_lo6;
  logic [29:0]  r24_6;
  logic [30:0]  e30_6;
  logic         zero6;
  logic [35:0]  poly7;
  logic [30:0]  e30_7;
  logic         zero7;

  logic [61:0]  r_prod;
  logic [29:0]  r24_w;
  logic [59:0]  sq_full;
  logic [53:0]  tneg;
  logic [7:0]   nsh;
  logic [TBL_BITS-1:0] idx6;
  logic [MANT_W-1:0]   m6;
  logic [71:0]  q_full;
  logic [66:0]  f_full;
  logic [42:0]  f_trunc;

  assign r_prod  = p3[42:7] * SQRT5_Q24;
  assign r24_w   = r32_4[37:8];
  assign sq_full = r24_w * r24_w;
  assign tneg    = 54'd0 - {1'b0, tmag5};
  assign nsh     = 8'd0 - tneg[53:46];
  assign idx6    = tneg[45 -: TBL_BITS];
  assign q_full  = {pp_hi6, 18'b0} + {18'b0, pp_lo6};
  assign f_full  = poly7 * e30_7;
  assign f_trunc = f_full[66:24];

  m52_exp_rom #(.TBL_BITS(TBL_BITS)) u_rom (.idx(idx6), .mant(m6));

  always_ff @(posedge clk) begin
    if (en) begin
      a1     <= a;
      b1     <= b;
      diff2  <= (a1 > b1) ? (a1 - b1) : (b1 - a1);
      p3     <= diff2 * scale;
      big3   <= scale_big && (diff2 != '0);
      // distance of sixteen or more gives a zero factor
      zero4  <= big3 || (|p3[58:43]);
      r32_4  <= r_prod[61:24];
      zero5  <= zero4;
      r24_5  <= r24_w;
      sq5    <= sq_full[59:24];
      tmag5  <= r32_4[37:16] * LOG2E_Q30;
      zero6  <= zero5;
      r24_6  <= r24_5;
      pp_hi6 <= sq5[35:18] * DIV3_M;
      pp_lo6 <= sq5[17:0] * DIV3_M;
      e30_6  <= (nsh >= 8'd31) ? '0 : (m6 >> nsh[4:0]);
      zero7  <= zero6;
      e30_7  <= e30_6;
      poly7  <= 36'(ONE_Q24) + 36'(r24_6) + 36'(q_full[71:37]);
      if (zero7)                       factor <= '0;
      else if (f_trunc > 43'(ONE_Q30)) factor <= ONE_Q30;
      else                             factor <= f_trunc[FACT_W-1:0];
    end
  end

endmodule

[hdl/matern52_ard_kernel.sv]
// channel  | handshake            | payload
// ---------+----------------------+------------------------------------------
// input    | in_valid / in_ready  | first_x0..5, second_x0..5 (Q1.15)
// output   | out_valid/ out_ready | covariance (Q5.27), saturated
// config   | cfg_write            | cfg_index, cfg_data (Q5.11)
//
// one item per cycle unless the output stalls; 8 per-dimension stages
// (multipliers and the exp table feed the factor), 5 stages of factor
// products, one amplitude multiply and one output shift stage
// derived scales and amplitude follow a config write through the t_len/t_amp registers
// rst clears the config registers and the valid bits of the pipeline
// a stalled output freezes the whole pipeline; in_ready drops with it
module matern52_ard_kernel #(
  parameter int unsigned EXP_TABLE_BITS = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [15:0]                first_x0,
  input  logic [15:0]                first_x1,
  input  logic [15:0]                first_x2,
  input  logic [15:0]                first_x3,
  input  logic [15:0]                first_x4,
  input  logic [15:0]                first_x5,
  input  logic [15:0]                second_x0,
  input  logic [15:0]                second_x1,
  input  logic [15:0]                second_x2,
  input  logic [15:0]                second_x3,
  input  logic [15:0]                second_x4,
  input  logic [15:0]                second_x5,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [31:0]                covariance,
  output logic                       saturated,
  input  logic                       cfg_write,
  input  logic [m52_pkg::IDX_W-1:0]  cfg_index,
  input  logic [15:0]                cfg_data
);
  import m52_pkg::*;

  localparam int unsigned LANE_LAT = 8;
  localparam int unsigned LAT      = LANE_LAT + (NDIM - 1) + 2;

  cfg_derived_t cfg_d;
  logic         en;
  logic [LAT-1:0] vld;

  // pipeline moves whenever the output register is free or being taken
  assign en        = !vld[LAT-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  m52_cfg #(.TBL_BITS(EXP_TABLE_BITS)) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .derived   (cfg_d)
  );

  logic [15:0] xa [NDIM];
  logic [15:0] xb [NDIM];

  assign xa[0] = first_x0;   assign xb[0] = second_x0;
  assign xa[1] = first_x1;   assign xb[1] = second_x1;
  assign xa[2] = first_x2;   assign xb[2] = second_x2;
  assign xa[3] = first_x3;   assign xb[3] = second_x3;
  assign xa[4] = first_x4;   assign xb[4] = second_x4;
  assign xa[5] = first_x5;   assign xb[5] = second_x5;

  // per-dimension factor lanes
  logic [NDIM-1:0][FACT_W-1:0] fac;

  for (genvar i = 0; i < NDIM; i++) begin : g_lane
    m52_lane #(.TBL_BITS(EXP_TABLE_BITS)) u_lane (
      .clk       (clk),
      .en        (en),
      .a         (xa[i]),
      .b         (xb[i]),
      .scale     (cfg_d.scale[i]),
      .scale_big (cfg_d.scale_big[i]),
      .factor    (fac[i])
    );
  end

  // product chain, one factor per stage, truncated to Q.30 each time
  logic [FACT_W-1:0]           prod  [1:NDIM-1];
  logic [NDIM-1:0][FACT_W-1:0] fpipe [1:NDIM-1];

  for (genvar j = 1; j < NDIM; j++) begin : g_prod
    logic [FACT_W-1:0]           lhs;
    logic [NDIM-1:0][FACT_W-1:0] src;
    logic [2*FACT_W-1:0]         pw;

    if (j == 1) begin : g_first
      assign lhs = fac[0];
      assign src = fac;
    end else begin : g_next
      assign lhs = prod[j-1];
      assign src = fpipe[j-1];
    end

    assign pw = lhs * src[j];

    always_ff @(posedge clk) begin
      if (en) begin
        prod[j]  <= pw[60:30];
        fpipe[j] <= src;
      end
    end
  end

  // amplitude multiply
  logic [61:0] mp;

  always_ff @(posedge clk) begin
    if (en) mp <= cfg_d.amp_mant * prod[NDIM-1];
  end

  // final shift into Q5.27 with saturation
  logic signed [7:0] sh;
  logic [7:0]        nsh;
  logic [75:0]       wide;
  logic [61:0]       rsh;
  logic [31:0]       cov_next;
  logic              sat_next;

  always_comb begin
    sh   = 8'(cfg_d.amp_exp) - 8'sd33;
    nsh  = 8'd0 - sh;
    wide = {14'd0, mp} << sh[3:0];
    rsh  = (nsh >= 8'd62) ? '0 : (mp >> nsh[5:0]);
    if (!sh[7]) begin
      sat_next = |wide[75:32];
      cov_next = wide[31:0];
    end else begin
      sat_next = |rsh[61:32];
      cov_next = rsh[31:0];
    end
    if (sat_next) cov_next = '1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      covariance <= cov_next;
      saturated  <= sat_next;
    end
  end

`ifndef SYNTHESIS
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> covariance == 32'hFFFF_FFFF)
    else $error("saturated item without full-scale covariance");

  a_stall_back: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  a_factor_range: assert property (@(posedge clk) disable iff (rst)
    vld[LANE_LAT-1] |-> (fac[0] <= ONE_Q30) && (fac[1] <= ONE_Q30) &&
      (fac[2] <= ONE_Q30) && (fac[3] <= ONE_Q30) && (fac[4] <= ONE_Q30) &&
      (fac[5] <= ONE_Q30))
    else $error("dimension factor above one");
`endif

endmodule

[test/matern52_checker.sv]
`timescale 1ns / 100ps

module matern52_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [15:0] first_x0,
  input  logic [15:0] first_x1,
  input  logic [15:0] first_x2,
  input  logic [15:0] first_x3,
  input  logic [15:0] first_x4,
  input  logic [15:0] first_x5,
  input  logic [15:0] second_x0,
  input  logic [15:0] second_x1,
  input  logic [15:0] second_x2,
  input  logic [15:0] second_x3,
  input  logic [15:0] second_x4,
  input  logic [15:0] second_x5,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] covariance,
  input  logic        saturated,
  input  logic        cfg_write,
  input  logic [m52_pkg::IDX_W-1:0] cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  localparam int          TBL_BITS = 8;
  localparam longint      LOG2E    = 64'd1549082005;
  localparam logic [63:0] LN2      = 64'd744261118;
  localparam logic [63:0] SQRT5    = 64'd37514995;
  localparam logic [63:0] ONE30    = 64'd1 << 30;
  localparam logic [63:0] ONE24    = 64'd1 << 24;
  localparam logic [63:0] DIST_CAP = 64'd1 << 43;
  localparam logic [63:0] MAX32    = 64'hFFFF_FFFF;

  typedef struct packed {
    logic [31:0] cov;
    logic        sat;
  } kernel_out_t;

  logic [15:0] log_params [7];
  kernel_out_t cov_q [$];

  function automatic logic [63:0] pow2_frac(int unsigned idx);
    logic [63:0] y, sum, term;
    y = (64'(idx) * LN2) >> TBL_BITS;
    sum = ONE30;
    term = ONE30;
    for (int n = 1; n <= 24; n++) begin
      term = ((term * y) >> 30) / 64'(n);
      sum = sum + term;
    end
    return sum;
  endfunction

  function automatic void exp_split(input longint x16, output logic [63:0] m, output int k);
    longint t, kk, frac;
    t = x16 * LOG2E;
    kk = t >>> 46;
    frac = t - (kk <<< 46);
    m = pow2_frac(int'((frac >> (46 - TBL_BITS)) & ((1 << TBL_BITS) - 1)));
    k = int'(kk);
  endfunction

  function automatic logic [63:0] exp_fixed(longint x16, int outfrac);
    logic [63:0] m;
    int k, sh;
    exp_split(x16, m, k);
    sh = k + outfrac - 30;
    if (sh >= 0) return (sh >= 63) ? 64'd0 : (m << sh);
    if (sh <= -63) return 64'd0;
    return m >> (-sh);
  endfunction

  // one dimension's matern factor in Q.30
  function automatic logic [63:0] dim_factor(logic [15:0] a, logic [15:0] b, logic [15:0] lraw);
    logic [63:0] diff, s, p, d32, r32, r24, sq, poly, e30, f;
    longint len;
    diff = (a > b) ? 64'(a - b) : 64'(b - a);
    len = longint'($signed(lraw));
    s = exp_fixed(-len * 32, 24);
    p = diff * s;
    if (p >= DIST_CAP) return 64'd0;  // far apart: factor is zero
    d32 = p >> 7;
    r32 = (d32 * SQRT5) >> 24;
    r24 = r32 >> 8;
    sq = (r24 * r24) >> 24;
    poly = ONE24 + r24 + sq / 64'd3;
    e30 = exp_fixed(-longint'(r32 >> 16), 30);
    f = (poly * e30) >> 24;
    if (f > ONE30) f = ONE30;
    return f;
  endfunction

  function automatic kernel_out_t kernel_value(logic [15:0] fa [6], logic [15:0] fb [6]);
    logic [63:0] prod, m, mp, cov;
    int k, sh;
    kernel_out_t r;
    prod = ONE30;
    for (int i = 0; i < 6; i++)
      prod = (prod * dim_factor(fa[i], fb[i], log_params[i + 1])) >> 30;
    exp_split(longint'($signed(log_params[0])) * 64, m, k);
    mp = m * prod;
    sh = k - 33;
    r.sat = 1'b0;
    if (sh >= 0) begin
      if (mp != 0 && (sh >= 32 || mp > (MAX32 >> sh))) begin
        r.sat = 1'b1;
        cov = MAX32;
      end else begin
        cov = mp << sh;
      end
    end else begin
      cov = (sh <= -63) ? 64'd0 : (mp >> (-sh));
      if (cov > MAX32) begin
        r.sat = 1'b1;
        cov = MAX32;
      end
    end
    r.cov = cov[31:0];
    return r;
  endfunction

  always @(posedge clk) begin
    logic [15:0] fa [6];
    logic [15:0] fb [6];
    kernel_out_t want;
    if (rst) begin
      foreach (log_params[i]) log_params[i] <= '0;
    end else begin
      if (cfg_write && cfg_index <= m52_pkg::REG_LOG_LENGTH_5)
        log_params[cfg_index] <= cfg_data;
      if (in_valid && in_ready) begin
        fa = '{first_x0, first_x1, first_x2, first_x3, first_x4, first_x5};
        fb = '{second_x0, second_x1, second_x2, second_x3, second_x4, second_x5};
        cov_q = {cov_q, kernel_value(fa, fb)};
      end
      if (out_valid && out_ready) begin
        if (cov_q.size() == 0) begin
          $error("result with no item pending: covariance %h", covariance);
          fail_count++;
        end else begin
          want = cov_q.pop_front();
          if (covariance !== want.cov) begin
            $error("covariance expected %h actual %h", want.cov, covariance);
            fail_count++;
          end
          if (saturated !== want.sat) begin
            $error("saturated expected %b actual %b", want.sat, saturated);
            fail_count++;
          end
        end
      end
      pending = cov_q.size();
    end
  end

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import m52_pkg::*;

  localparam int          CYCLE_LIMIT = 300000;
  localparam int          DRAIN_WAIT  = 24;     // pipeline depth plus config settle
  localparam logic [2:0]  REG_UNUSED  = 3'd7;   // no register there, write is dropped

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [15:0] fx [6];
  logic [15:0] sx [6];
  logic        out_valid;
  logic        out_ready;
  logic [31:0] covariance;
  logic        saturated;
  logic        cfg_write;
  logic [IDX_W-1:0] cfg_index;
  logic [15:0] cfg_data;
  int          fail_count;
  int          pending;
  int          cycles;
  bit          quiet;      // no idling on either side
  bit          hold_req;   // asks the receiver for one long hold-off

  matern52_ard_kernel u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .first_x0(fx[0]), .first_x1(fx[1]), .first_x2(fx[2]),
    .first_x3(fx[3]), .first_x4(fx[4]), .first_x5(fx[5]),
    .second_x0(sx[0]), .second_x1(sx[1]), .second_x2(sx[2]),
    .second_x3(sx[3]), .second_x4(sx[4]), .second_x5(sx[5]),
    .out_valid(out_valid), .out_ready(out_ready),
    .covariance(covariance), .saturated(saturated),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  matern52_checker u_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .first_x0(fx[0]), .first_x1(fx[1]), .first_x2(fx[2]),
    .first_x3(fx[3]), .first_x4(fx[4]), .first_x5(fx[5]),
    .second_x0(sx[0]), .second_x1(sx[1]), .second_x2(sx[2]),
    .second_x3(sx[3]), .second_x4(sx[4]), .second_x5(sx[5]),
    .out_valid(out_valid), .out_ready(out_ready),
    .covariance(covariance), .saturated(saturated),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("[matern52_ard_kernel] ERROR");
        $finish;
      end
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (400) @(negedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end else begin
        out_ready = 1'b1;
        @(negedge clk);
      end
    end
  end

  // present one point pair and hold it until the block takes it
  task automatic send_pair(input logic [15:0] a [6], input logic [15:0] b [6]);
    @(negedge clk);
    fx = a;
    sx = b;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(1, 12) - 1) @(negedge clk);
    end
  endtask

  // let every item come out and the pipeline empty before touching config
  task automatic drain;
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic set_all(input logic [15:0] amp, input logic [15:0] len [6]);
    write_reg(REG_LOG_AMPLITUDE, amp);
    write_reg(REG_LOG_LENGTH_0, len[0]);
    write_reg(REG_LOG_LENGTH_1, len[1]);
    write_reg(REG_LOG_LENGTH_2, len[2]);
    write_reg(REG_LOG_LENGTH_3, len[3]);
    write_reg(REG_LOG_LENGTH_4, len[4]);
    write_reg(REG_LOG_LENGTH_5, len[5]);
    repeat (4) @(posedge clk);  // derived scales settle
  endtask

  // mostly in [0,1], sometimes any 16-bit value
  function automatic logic [15:0] rand_coord();
    if ($urandom_range(0, 7) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 32768));
  endfunction

  // random pair, often close so the factors stay away from zero
  task automatic send_random;
    logic [15:0] a [6];
    logic [15:0] b [6];
    int near;
    near = $urandom_range(0, 2);
    foreach (a[i]) begin
      a[i] = rand_coord();
      if (near == 0) b[i] = rand_coord();
      else b[i] = a[i] + 16'($urandom_range(0, 2048)) - 16'd1024;
    end
    send_pair(a, b);
  endtask

  // moderate settings: log scales within about plus or minus two
  task automatic set_random;
    logic [15:0] len [6];
    foreach (len[i]) len[i] = 16'($urandom_range(0, 8192)) - 16'd4096;
    set_all(16'($urandom_range(0, 8192)) - 16'd4096, len);
  endtask

  initial begin
    logic [15:0] a [6];
    logic [15:0] b [6];
    logic [15:0] len [6];
    rst = 1'b1;
    in_valid = 1'b0;
    foreach (fx[i]) fx[i] = '0;
    foreach (sx[i]) sx[i] = '0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    quiet = 1'b0;
    hold_req = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed, reset config: equal points, extreme distances, coords above one
    a = '{default: 16'd0};      b = '{default: 16'd0};      send_pair(a, b);
    a = '{default: 16'd32768};  b = '{default: 16'd0};      send_pair(a, b);
    a = '{default: 16'hFFFF};   b = '{default: 16'd0};      send_pair(a, b);
    a = '{default: 16'd0};      b = '{default: 16'hFFFF};   send_pair(a, b);
    a = '{default: 16'd40000};  b = '{default: 16'd40000};  send_pair(a, b);
    a = '{default: 16'd1};      b = '{default: 16'd0};      send_pair(a, b);
    a = '{16'd32768, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
    b = '{default: 16'd0};      send_pair(a, b);
    drain();

    // shortest lengths: far apart for almost any distance
    len = '{default: 16'h8000};
    set_all(16'h0000, len);
    a = '{default: 16'd1};      b = '{default: 16'd0};      send_pair(a, b);
    a = '{default: 16'd0};      b = '{default: 16'd0};      send_pair(a, b);
    a = '{default: 16'hFFFF};   b = '{default: 16'h0000};   send_pair(a, b);
    drain();

    // longest lengths, largest amplitude: factor near one, output saturates
    len = '{default: 16'h7FFF};
    set_all(16'h7FFF, len);
    a = '{default: 16'd0};      b = '{default: 16'd0};      send_pair(a, b);
    a = '{default: 16'hFFFF};   b = '{default: 16'd0};      send_pair(a, b);
    a = '{default: 16'd100};    b = '{default: 16'd32768};  send_pair(a, b);
    drain();

    // smallest amplitude, dropped write to a missing register
    set_all(16'h8000, len);
    write_reg(REG_UNUSED, 16'h1234);
    a = '{default: 16'd0};      b = '{default: 16'd0};      send_pair(a, b);
    a = '{default: 16'd5000};   b = '{default: 16'd0};      send_pair(a, b);
    drain();

    // amplitude right at the edge of the output range
    len = '{default: 16'h0000};
    set_all(16'd3500, len);
    a = '{default: 16'd0};      b = '{default: 16'd0};      send_pair(a, b);
    a = '{default: 16'd300};    b = '{default: 16'd0};      send_pair(a, b);
    drain();
    set_all(16'd3600, len);
    a = '{default: 16'd0};      b = '{default: 16'd0};      send_pair(a, b);
    drain();

    // random phases, the second with the long output hold-off
    for (int phase = 0; phase < 5; phase++) begin
      set_random();
      if (phase == 1) hold_req = 1'b1;
      if (phase == 4) quiet = 1'b1;
      repeat (100) send_random();
      drain();
    end

    // mixed extremes per dimension, no idling
    len = '{16'h8000, 16'h7FFF, 16'h0000, 16'hF800, 16'h0800, 16'h1000};
    set_all(16'h0400, len);
    repeat (30) send_random();
    drain();

    if (fail_count == 0)
      $display("[matern52_ard_kernel] OK");
    else
      $display("[matern52_ard_kernel] ERROR");
    $finish;
  end

endmodule
